/* rtl/sfd_pkg.sv */
// Package for the sensor frame decoder: status codes, frame constants,
// the queue entry type and the CRC-8 byte update. No dependencies.
`timescale 1ns / 1ps

package sfd_pkg;

  // Result status codes.
  typedef enum logic [1:0] {
    STATUS_OK      = 2'd0,
    STATUS_HDR_ERR = 2'd1,
    STATUS_CRC_ERR = 2'd2
  } status_e;

  // Frame layout: bytes 0 to 3 are held, byte 4 is the check byte.
  localparam int unsigned PosWidth = 3;
  localparam logic [PosWidth-1:0] PosCheck = 3'd4;
  localparam logic [PosWidth-1:0] PosIdle  = 3'd5;

  localparam logic [7:0] CrcPoly = 8'h31;
  localparam logic [3:0] HdrNibLo = 4'h8;
  localparam logic [3:0] HdrNibHi = 4'h9;
  localparam logic [11:0] TempOffset = 12'd400;
  localparam logic [6:0] HumAbsent = 7'h6A;

  // Depth of the queue between the front and the back.
  localparam int unsigned QueueDepth = 2;
  localparam int unsigned QueuePtrW  = $clog2(QueueDepth);
  localparam int unsigned QueueCntW  = $clog2(QueueDepth + 1);

  // One classified frame, as handed from the front to the back.
  typedef struct packed {
    status_e     status;
    logic [5:0]  sensor_id;
    logic        new_battery;
    logic [11:0] temp_bcd;
    logic [7:0]  byte3;
  } frame_t;

  // Queue fill status seen by the front and the back.
  typedef struct packed {
    logic full;
    logic empty;
  } queue_stat_t;

  // MSB-first CRC-8 update over one byte.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    logic [7:0] d;
    logic       top;
    c = crc;
    d = b;
    for (int i = 0; i < 8; i++) begin
      top = c[7] ^ d[7];
      c   = {c[6:0], 1'b0};
      if (top) begin
        c = c ^ CrcPoly;
      end
      d = {d[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

/* rtl/sfd_if.sv */
// Handshake channels of the sensor frame decoder: the byte input channel
// and the decoded result channel. No dependencies.
`timescale 1ns / 1ps

interface sfd_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       frame_start;

  modport source (output valid, data_byte, frame_start, input ready);
  modport sink (input valid, data_byte, frame_start, output ready);
endinterface

interface sfd_result_if;
  logic               valid;
  logic               ready;
  logic [1:0]         status;
  logic [5:0]         sensor_id;
  logic               new_battery;
  logic signed [11:0] temp_tenths;
  logic               battery_low;
  logic [6:0]         humidity;
  logic               humidity_present;

  modport source (output valid, status, sensor_id, new_battery, temp_tenths,
                  battery_low, humidity, humidity_present, input ready);
  modport sink (input valid, status, sensor_id, new_battery, temp_tenths,
                battery_low, humidity, humidity_present, output ready);
endinterface

/* rtl/sfd_front.sv */
// Front of the sensor frame decoder: assembles frames byte by byte, runs
// the CRC and classifies each frame into a queue entry. Uses sfd_pkg, sfd_if.
`timescale 1ns / 1ps

module sfd_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  sfd_byte_if.sink            byte_i,
  input  sfd_pkg::queue_stat_t q_stat_i,
  output logic                push_o,
  output sfd_pkg::frame_t     entry_o
);
  import sfd_pkg::*;

  logic [PosWidth-1:0] pos_q, pos_d, pos_eff;
  logic [7:0]          crc_q, crc_d, crc_eff;
  logic [7:0]          held_q [4];
  logic                accept;
  logic                hdr_ok;

  // A byte is taken whenever the queue can take a frame.
  assign byte_i.ready = !q_stat_i.full;
  assign accept = byte_i.valid && byte_i.ready;

  // A start flag restarts the frame and the CRC.
  assign pos_eff = byte_i.frame_start ? '0 : pos_q;
  assign crc_eff = byte_i.frame_start ? '0 : crc_q;

  // Position and CRC update.
  always_comb begin
    pos_d = pos_q;
    crc_d = crc_q;
    if (accept) begin
      if (pos_eff < PosCheck) begin
        pos_d = pos_eff + 1'b1;
        crc_d = crc8_byte(crc_eff, byte_i.data_byte);
      end else if (pos_eff == PosCheck) begin
        pos_d = PosIdle;
        crc_d = crc_eff;
      end else begin
        pos_d = pos_eff;
        crc_d = crc_eff;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      crc_q <= '0;
    end else begin
      pos_q <= pos_d;
      crc_q <= crc_d;
    end
  end

  // Hold frame bytes 0 to 3.
  always_ff @(posedge clk_i) begin
    if (accept && (pos_eff < PosCheck)) begin
      held_q[pos_eff[1:0]] <= byte_i.data_byte;
    end
  end

  // The check byte closes the frame and classifies it.
  assign push_o = accept && (pos_eff == PosCheck);
  assign hdr_ok = (held_q[0][7:4] == HdrNibLo) || (held_q[0][7:4] == HdrNibHi);

  always_comb begin
    if (!hdr_ok) begin
      entry_o.status = STATUS_HDR_ERR;
    end else if (byte_i.data_byte != crc_q) begin
      entry_o.status = STATUS_CRC_ERR;
    end else begin
      entry_o.status = STATUS_OK;
    end
    entry_o.sensor_id   = {held_q[0][3:0], held_q[1][7:6]};
    entry_o.new_battery = held_q[1][5];
    entry_o.temp_bcd    = {held_q[1][3:0], held_q[2]};
    entry_o.byte3       = held_q[3];
  end

  // The position never runs past the idle value.
  a_pos_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= PosIdle)
    else $error("frame position out of range");

  // A frame entry leaves exactly when the check byte is taken, and the
  // front then rests until the next start flag.
  a_push_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> (pos_q == PosIdle))
    else $error("front did not go idle after the check byte");

endmodule

/* rtl/sfd_fifo.sv */
// Short queue of classified frames between the front and the back of the
// sensor frame decoder. Uses sfd_pkg.
`timescale 1ns / 1ps

module sfd_fifo (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  sfd_pkg::frame_t      push_data_i,
  input  logic                 pop_i,
  output sfd_pkg::frame_t      pop_data_o,
  output sfd_pkg::queue_stat_t stat_o
);
  import sfd_pkg::*;

  frame_t               mem_q [QueueDepth];
  logic [QueuePtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [QueueCntW-1:0] cnt_q;
  logic                 do_push, do_pop;

  assign stat_o.full  = (cnt_q == QueueCntW'(QueueDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign do_push = push_i && !stat_o.full;
  assign do_pop  = pop_i && !stat_o.empty;
  assign pop_data_o = mem_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Pointers wrap at the queue depth; the count tracks the fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == QueuePtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

  // The front never offers a frame to a full queue.
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !stat_o.full)
    else $error("push into a full frame queue");

  // The fill level never exceeds the depth.
  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QueueCntW'(QueueDepth))
    else $error("frame queue count out of range");

endmodule

/* rtl/sfd_back.sv */
// Back of the sensor frame decoder: takes classified frames from the queue,
// decodes temperature and humidity and holds the result word. Uses sfd_pkg, sfd_if.
`timescale 1ns / 1ps

module sfd_back (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  sfd_pkg::queue_stat_t q_stat_i,
  input  sfd_pkg::frame_t      entry_i,
  output logic                 pop_o,
  sfd_result_if.source         result_o
);
  import sfd_pkg::*;

  logic               vld_q;
  logic [1:0]         status_q, status_d;
  logic [5:0]         id_q, id_d;
  logic               newbat_q, newbat_d;
  logic signed [11:0] temp_q, temp_d;
  logic               batlow_q, batlow_d;
  logic [6:0]         hum_q, hum_d;
  logic               humpres_q, humpres_d;
  logic [11:0]        temp_sum;
  logic               ok;

  // Take the next frame when the result register is free or being emptied.
  assign pop_o = !q_stat_i.empty && (!vld_q || result_o.ready);

  // BCD temperature: hundreds, tens and units of tenths, less the offset.
  assign temp_sum = 12'(entry_i.temp_bcd[11:8]) * 12'd100
                  + 12'(entry_i.temp_bcd[7:4]) * 12'd10
                  + 12'(entry_i.temp_bcd[3:0]) - TempOffset;

  // Error results carry only the status; every other field is zero.
  assign ok = (entry_i.status == STATUS_OK);

  always_comb begin
    status_d  = entry_i.status;
    id_d      = ok ? entry_i.sensor_id : '0;
    newbat_d  = ok && entry_i.new_battery;
    temp_d    = ok ? $signed(temp_sum) : '0;
    batlow_d  = ok && entry_i.byte3[7];
    hum_d     = ok ? entry_i.byte3[6:0] : '0;
    humpres_d = ok && (entry_i.byte3[6:0] != HumAbsent);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (pop_o) begin
      vld_q <= 1'b1;
    end else if (result_o.ready) begin
      vld_q <= 1'b0;
    end
  end

  // Result word register.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      status_q  <= status_d;
      id_q      <= id_d;
      newbat_q  <= newbat_d;
      temp_q    <= temp_d;
      batlow_q  <= batlow_d;
      hum_q     <= hum_d;
      humpres_q <= humpres_d;
    end
  end

  assign result_o.valid            = vld_q;
  assign result_o.status           = status_q;
  assign result_o.sensor_id        = id_q;
  assign result_o.new_battery      = newbat_q;
  assign result_o.temp_tenths      = temp_q;
  assign result_o.battery_low      = batlow_q;
  assign result_o.humidity         = hum_q;
  assign result_o.humidity_present = humpres_q;

  // A failed frame shows no decoded fields.
  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (vld_q && (status_q != STATUS_OK)) |->
      ((id_q == '0) && !newbat_q && (temp_q == '0) && !batlow_q &&
       (hum_q == '0) && !humpres_q))
    else $error("error result carries decoded fields");

endmodule

/* rtl/sensor_frame_crc8_decoder.sv */
// Top level of the sensor frame decoder: front, frame queue and back.
// Uses sfd_pkg, sfd_if, sfd_front, sfd_fifo and sfd_back.
`timescale 1ns / 1ps

// Decodes 5-byte wireless temperature sensor frames taken one byte per
// word on byte_i. A word with frame_start set begins a new frame; after
// reset the first word is byte 0 even without it. Bytes 0 to 3 run through
// an MSB-first CRC-8 (polynomial 0x31, initial value 0), byte 4 is the
// check byte, and one result word follows each complete frame on result_o
// with status ok, header error or CRC error (only the first failure is
// reported, and error words carry zero in every other field). Bytes after
// the check byte without a start flag are dropped. The block takes one byte
// per cycle while the frame queue is not full; the CRC of a byte is
// computed in the cycle it is taken. A finished frame is written into the
// frame queue and from there decoded into the result register once that
// register is free or being emptied, and its result word is valid from there.
// A two-entry frame queue sits between the front and the back, so input
// stalls only when two finished frames are waiting behind a held result.
module sensor_frame_crc8_decoder (
  input  logic         clk_i,
  input  logic         rst_ni,
  sfd_byte_if.sink     byte_i,
  sfd_result_if.source result_o
);
  import sfd_pkg::*;

  logic        push;
  logic        pop;
  frame_t      push_entry;
  frame_t      pop_entry;
  queue_stat_t q_stat;

  sfd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .byte_i   (byte_i),
    .q_stat_i (q_stat),
    .push_o   (push),
    .entry_o  (push_entry)
  );

  sfd_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_entry),
    .pop_i       (pop),
    .pop_data_o  (pop_entry),
    .stat_o      (q_stat)
  );

  sfd_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .q_stat_i (q_stat),
    .entry_i  (pop_entry),
    .pop_o    (pop),
    .result_o (result_o)
  );

endmodule
